>>> rtl/b58e_pkg.sv
// b58e_pkg: shared types, constants and the alphabet lookup for the base58 encoder
// used by b58e_divmod and base58_encoder_unit; depends on nothing
`timescale 1ns / 1ps

package b58e_pkg;

	// default sizing of the unit
	localparam int MAX_BYTES_DEF = 128;
	localparam int DIGIT_CAP_DEF = 128;
	localparam int CPR_DEF       = 8;
	localparam int RESULT_LIMIT  = 32;

	// field and datapath widths
	localparam int DATA_W    = 8;
	localparam int CAP_REG_W = 10;
	localparam int PACK_W    = 64;
	localparam int COUNT_W   = 4;
	localparam int DIGIT_W   = 6;
	localparam int CARRY_W   = 8;
	localparam int CHAR_W    = 8;

	localparam logic [CAP_REG_W-1:0] CAP_RESET = 10'd256;

	// divide by 58 through a reciprocal: q = (v * 1130) >> 16, exact for v < 16384
	localparam int RECIP       = 1130;
	localparam int RECIP_SHIFT = 16;

	// length bound on the digit store: len * 138 / 100 + 1 must fit
	localparam int RANGE_NUM = 138;
	localparam int RANGE_DEN = 100;

	localparam logic [CHAR_W-1:0] CHAR_ONE = 8'h31;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_RANGE  = 2'd1,
		STATUS_BUFFER = 2'd2
	} status_t;

	// input word
	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              last_byte;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [PACK_W-1:0]  char_pack;
		logic [COUNT_W-1:0] char_count;
		logic               final_chunk;
		status_t            status;
	} out_word_t;

	// base58 digit to ascii, alphabet without 0, O, I and l
	function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] idx);
		logic [CHAR_W-1:0] i8;
		logic [CHAR_W-1:0] ch;
		i8 = {2'b00, idx};
		priority if (i8 < 8'd9) begin
			ch = 8'h31 + i8;
		end else if (i8 < 8'd17) begin
			ch = 8'h41 + i8 - 8'd9;
		end else if (i8 < 8'd22) begin
			ch = 8'h4A + i8 - 8'd17;
		end else if (i8 < 8'd33) begin
			ch = 8'h50 + i8 - 8'd22;
		end else if (i8 < 8'd44) begin
			ch = 8'h61 + i8 - 8'd33;
		end else if (i8 < 8'd58) begin
			ch = 8'h6D + i8 - 8'd44;
		end else begin
			ch = 8'h00;
		end
		return ch;
	endfunction

endpackage

>>> rtl/b58e_ram.sv
// b58e_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module b58e_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/b58e_divmod.sv
// b58e_divmod: shared digit step, (256 * digit + carry) split into quotient and remainder by 58
// depends on b58e_pkg
`timescale 1ns / 1ps

module b58e_divmod (
	input  logic [b58e_pkg::DIGIT_W-1:0] digit,
	input  logic [b58e_pkg::CARRY_W-1:0] carry_in,
	output logic [b58e_pkg::CARRY_W-1:0] quot,
	output logic [b58e_pkg::DIGIT_W-1:0] rem
);

	localparam int ACC_W  = b58e_pkg::DIGIT_W + b58e_pkg::CARRY_W;
	localparam int PROD_W = ACC_W + 11;

	logic [ACC_W-1:0]  acc;
	logic [PROD_W-1:0] prod;
	logic [ACC_W-1:0]  q58;
	logic [ACC_W-1:0]  diff;

	// 256 * digit + carry is a concatenation since carry stays below 256
	assign acc = {digit, carry_in};

	// reciprocal multiply, quotient stays below 256
	assign prod = PROD_W'(acc) * PROD_W'(b58e_pkg::RECIP);
	assign quot = prod[b58e_pkg::RECIP_SHIFT +: b58e_pkg::CARRY_W];

	// 58 * q = 64q - 4q - 2q
	assign q58  = {quot, 6'b000000} - {4'b0000, quot, 2'b00} - {5'b00000, quot, 1'b0};
	assign diff = acc - q58;
	assign rem  = diff[b58e_pkg::DIGIT_W-1:0];

endmodule

>>> rtl/base58_encoder_unit.sv
// base58_encoder_unit: base58 (bitcoin alphabet) encoder of a byte string, top level
// depends on b58e_pkg, b58e_ram, b58e_divmod
//
// Bytes enter one per start pulse, most significant first, with last_byte on the final one.
// A leading zero byte, or a byte after the length limit, is taken in the idle state with no
// fold. Every other byte is folded into the base-58 digit store one digit per cycle through
// the single divide-by-58 unit and the one read port of the store; busy stays high until
// the whole store has been folded, and only then can the next byte follow. After the last
// byte the unit checks the length bounds, scans the store (once a fold has written it) for
// the first nonzero digit, sizes the string and then produces one character per cycle into
// result words of up to CHARS_PER_RESULT characters. Each result is presented on result for
// exactly one cycle with result_strobe high; there is no backpressure, so the receiver must
// take every word as it comes. An error gives a single final word with no characters. The
// digit store is masked until the first fold of a string writes it, so no clearing pass is
// needed after reset or between strings. output_capacity is written through cfg_write /
// cfg_data; the user must do so only while the unit is idle, the block does not enforce it.
`timescale 1ns / 1ps

module base58_encoder_unit #(
	parameter int MAX_BYTES        = b58e_pkg::MAX_BYTES_DEF,
	parameter int DIGIT_CAP        = b58e_pkg::DIGIT_CAP_DEF,
	parameter int CHARS_PER_RESULT = b58e_pkg::CPR_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  b58e_pkg::in_word_t                 item,
	input  logic                               cfg_write,
	input  logic [b58e_pkg::CAP_REG_W-1:0]     cfg_data,
	output logic                               result_strobe,
	output b58e_pkg::out_word_t                result
);

	localparam int AW     = $clog2(DIGIT_CAP);
	localparam int CW     = $clog2(DIGIT_CAP + 1);
	localparam int BW     = $clog2(MAX_BYTES + 1);
	localparam int TW     = ((BW > CW) ? BW : CW) + 1;
	localparam int CHK_W  = 16;
	localparam int CMP_W  = 11;
	localparam int DW     = b58e_pkg::DIGIT_W;

	localparam logic [CHK_W-1:0] RANGE_LIM = CHK_W'(DIGIT_CAP * b58e_pkg::RANGE_DEN);
	localparam logic [CMP_W-1:0] WIN_LIM   = CMP_W'(b58e_pkg::RESULT_LIMIT * CHARS_PER_RESULT);
	localparam logic [2:0]       SLOT_LAST = 3'(CHARS_PER_RESULT - 1);
	localparam logic [CW-1:0]    CAP_CNT   = CW'(DIGIT_CAP);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_FOLD   = 6'b000010,
		ST_FINISH = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_SIZE   = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t state_q;

	// per-string bookkeeping
	logic [BW-1:0] bc_q;
	logic [BW-1:0] lz_q;
	logic          nz_seen_q;
	logic          too_long_q;
	logic          live_q;
	logic          last_q;
	logic [b58e_pkg::CAP_REG_W-1:0] cap_q;

	// sequencer registers
	logic [CW-1:0]                cnt_q;
	logic [b58e_pkg::CARRY_W-1:0] carry_q;
	logic [CW-1:0]                first_q;
	logic [TW-1:0]                total_q;
	logic [TW-1:0]                chr_q;
	logic [CW-1:0]                ptr_q;

	// read stage
	logic          vld_s1;
	logic [AW-1:0] addr_s1;
	logic          lead_s1;
	logic          last_s1;

	// packing
	logic [b58e_pkg::PACK_W-1:0] pack_q;
	logic [2:0]                  slot_q;
	b58e_pkg::out_word_t         result_q;
	logic                        strobe_q;

	// store and shared unit
	logic                          ram_we;
	logic                          ram_re;
	logic [AW-1:0]                 rd_addr;
	logic [DW-1:0]                 ram_rdata;
	logic [DW-1:0]                 digit_in;
	logic [b58e_pkg::CARRY_W-1:0]  dm_quot;
	logic [DW-1:0]                 dm_rem;

	// combinational decisions
	logic                         issue;
	logic                         is_lead;
	logic                         take_byte;
	logic                         set_too_long;
	logic                         lead_zero;
	logic                         need_fold;
	logic [BW-1:0]                nz_len;
	logic                         rng_bad;
	logic [TW-1:0]                total_n;
	logic                         cap_bad;
	logic                         win_bad;
	logic                         end_str;
	logic [b58e_pkg::CHAR_W-1:0]  ch;
	logic [b58e_pkg::PACK_W-1:0]  pack_n;
	logic                         chunk_end;

	assign busy          = (state_q != ST_IDLE);
	assign result        = result_q;
	assign result_strobe = strobe_q;

	// digit store
	b58e_ram #(
		.WIDTH(DW),
		.DEPTH(DIGIT_CAP)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(addr_s1),
		.wr_data(dm_rem),
		.rd_en  (ram_re),
		.rd_addr(rd_addr),
		.rd_data(ram_rdata)
	);

	// store reads as zero until the first fold of the string has written it
	assign digit_in = live_q ? ram_rdata : '0;

	b58e_divmod u_divmod (
		.digit   (digit_in),
		.carry_in(carry_q),
		.quot    (dm_quot),
		.rem     (dm_rem)
	);

	assign ram_we = vld_s1 && (state_q == ST_FOLD);

	// read issue per state
	always_comb begin
		issue   = 1'b0;
		is_lead = 1'b0;
		ram_re  = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			ST_FOLD: begin
				issue   = (cnt_q < CAP_CNT);
				ram_re  = issue;
				rd_addr = AW'(DIGIT_CAP - 1) - cnt_q[AW-1:0];
			end
			ST_SCAN: begin
				issue   = (cnt_q < CAP_CNT);
				ram_re  = issue;
				rd_addr = cnt_q[AW-1:0];
			end
			ST_EMIT: begin
				issue   = (chr_q < total_q);
				is_lead = (chr_q < TW'(lz_q));
				ram_re  = issue && !is_lead;
				rd_addr = ptr_q[AW-1:0];
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	// byte bookkeeping at accept
	assign take_byte    = !too_long_q && (bc_q < BW'(MAX_BYTES));
	assign set_too_long = !too_long_q && (bc_q >= BW'(MAX_BYTES));
	assign lead_zero    = !nz_seen_q && (item.data_byte == '0);
	assign need_fold    = take_byte && !lead_zero;

	// length bound: len * 138 / 100 + 1 > cap  <=>  len * 138 >= cap * 100
	assign nz_len  = bc_q - lz_q;
	assign rng_bad = (CHK_W'(nz_len) * CHK_W'(b58e_pkg::RANGE_NUM)) >= RANGE_LIM;

	// sizing of the output string
	assign total_n = TW'(lz_q) + TW'(CAP_CNT - first_q);
	assign cap_bad = (CMP_W'(total_n) + CMP_W'(1)) > CMP_W'(cap_q);
	assign win_bad = CMP_W'(total_n) > WIN_LIM;

	assign end_str = ((state_q == ST_FINISH) && (too_long_q || rng_bad))
		|| (state_q == ST_SIZE && (cap_bad || win_bad || total_n == '0))
		|| (state_q == ST_EMIT && vld_s1 && last_s1);

	// character assembly
	always_comb begin
		ch     = lead_s1 ? b58e_pkg::CHAR_ONE : b58e_pkg::b58_char(ram_rdata);
		pack_n = pack_q;
		pack_n[{slot_q, 3'b000} +: b58e_pkg::CHAR_W] = ch;
		chunk_end = last_s1 || (slot_q == SLOT_LAST);
	end

	// configuration register and per-string flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= b58e_pkg::CAP_RESET;
			bc_q       <= '0;
			lz_q       <= '0;
			nz_seen_q  <= 1'b0;
			too_long_q <= 1'b0;
			live_q     <= 1'b0;
		end else begin
			if (cfg_write) begin
				cap_q <= cfg_data;
			end
			if (end_str) begin
				bc_q       <= '0;
				lz_q       <= '0;
				nz_seen_q  <= 1'b0;
				too_long_q <= 1'b0;
				live_q     <= 1'b0;
			end else if (state_q == ST_IDLE && start) begin
				if (set_too_long) begin
					too_long_q <= 1'b1;
				end
				if (take_byte) begin
					bc_q <= bc_q + BW'(1);
					if (lead_zero) begin
						lz_q <= lz_q + BW'(1);
					end else begin
						nz_seen_q <= 1'b1;
					end
				end
			end else if (state_q == ST_FOLD && !issue && !vld_s1) begin
				live_q <= 1'b1;
			end
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= rd_addr;
			lead_s1 <= is_lead;
			last_s1 <= (chr_q == total_q - TW'(1));
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			slot_q   <= '0;
			pack_q   <= '0;
			result_q <= '0;
			last_q   <= 1'b0;
			cnt_q    <= '0;
			carry_q  <= '0;
			first_q  <= '0;
			total_q  <= '0;
			chr_q    <= '0;
			ptr_q    <= '0;
		end else begin
			// a word goes out at every string end and at every full chunk
			strobe_q <= end_str || (state_q == ST_EMIT && vld_s1 && chunk_end);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						last_q  <= item.last_byte;
						carry_q <= item.data_byte;
						cnt_q   <= '0;
						if (need_fold) begin
							state_q <= ST_FOLD;
						end else if (item.last_byte) begin
							state_q <= ST_FINISH;
						end
					end
				end
				// one digit per cycle, least significant first
				ST_FOLD: begin
					if (issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (vld_s1) begin
						carry_q <= dm_quot;
					end
					if (!issue && !vld_s1) begin
						state_q <= last_q ? ST_FINISH : ST_IDLE;
					end
				end
				// length checks
				ST_FINISH: begin
					if (too_long_q || rng_bad) begin
						result_q.char_pack   <= '0;
						result_q.char_count  <= '0;
						result_q.final_chunk <= 1'b1;
						result_q.status      <= b58e_pkg::STATUS_RANGE;
						state_q              <= ST_IDLE;
					end else if (!live_q) begin
						first_q <= CAP_CNT;
						state_q <= ST_SIZE;
					end else begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				// search for the first significant digit
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (vld_s1 && ram_rdata != '0) begin
						first_q <= CW'(addr_s1);
						state_q <= ST_SIZE;
					end else if (!issue && !vld_s1) begin
						first_q <= CAP_CNT;
						state_q <= ST_SIZE;
					end
				end
				// buffer checks, empty result word or start of output
				ST_SIZE: begin
					if (cap_bad || win_bad) begin
						result_q.char_pack   <= '0;
						result_q.char_count  <= '0;
						result_q.final_chunk <= 1'b1;
						result_q.status      <= b58e_pkg::STATUS_BUFFER;
						state_q              <= ST_IDLE;
					end else if (total_n == '0) begin
						result_q.char_pack   <= '0;
						result_q.char_count  <= '0;
						result_q.final_chunk <= 1'b1;
						result_q.status      <= b58e_pkg::STATUS_OK;
						state_q              <= ST_IDLE;
					end else begin
						total_q <= total_n;
						chr_q   <= '0;
						ptr_q   <= first_q;
						slot_q  <= '0;
						pack_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				// one character per cycle into the current word
				ST_EMIT: begin
					if (issue) begin
						chr_q <= chr_q + TW'(1);
						if (!is_lead) begin
							ptr_q <= ptr_q + CW'(1);
						end
					end
					if (vld_s1) begin
						if (chunk_end) begin
							result_q.char_pack   <= pack_n;
							result_q.char_count  <= b58e_pkg::COUNT_W'(slot_q) + 4'd1;
							result_q.final_chunk <= last_s1;
							result_q.status      <= b58e_pkg::STATUS_OK;
							pack_q               <= '0;
							slot_q               <= '0;
						end else begin
							pack_q <= pack_n;
							slot_q <= slot_q + 3'd1;
						end
						if (last_s1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result word only comes out of work in progress
	a_strobe_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result word without work in progress");

	// error words carry no characters and end the string
	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.status != b58e_pkg::STATUS_OK)
		|-> (result.char_count == '0 && result.final_chunk))
		else $error("error word with characters or not final");

	// word never holds more characters than configured
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (result.char_count <= b58e_pkg::COUNT_W'(CHARS_PER_RESULT)))
		else $error("character count above word size");

	// unit is free again once the final word is out
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.final_chunk) |-> !busy)
		else $error("still busy after final word");

	// store is only live once a nonzero byte has been taken
	a_live_store: assert property (@(posedge clk) disable iff (!arst_n)
		live_q |-> nz_seen_q)
		else $error("digit store live without a nonzero byte");

endmodule
